>>> rtl/gld_pkg.sv
// ----------------------------------------------------------------------------
// gld_pkg
// Shared types and constants for the LZW decoder.
// ----------------------------------------------------------------------------
package gld_pkg;

  localparam int MAX_WIDTH  = 12;
  localparam int STORE_BITS = 20;
  localparam int BYTE_BITS  = 8;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_PULL  = 2'd1,
    FUNC_START = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_BYTE   = 3'd0,
    ST_OK     = 3'd1,
    ST_NEED   = 3'd2,
    ST_FULL   = 3'd3,
    ST_END    = 3'd4,
    ST_ERROR  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    RUN_OK    = 2'd0,
    RUN_END   = 2'd1,
    RUN_ERROR = 2'd2
  } run_t;

endpackage

>>> rtl/gif_lzw_decoder.sv
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// Streaming LZW decompressor with variable code width up to 12 bits.
// ----------------------------------------------------------------------------
// Each input item is a push of one compressed byte, a pull of one decoded
// byte, a start of a new stream, or a no-op that reports NEED; each gives
// exactly one result item. Items are handled one at a time: the result of
// a push or start passes the dispatch and output states after the item is
// accepted, and the next input item is taken no earlier than the cycle
// after the result item leaves. A pull that pops an already expanded byte
// takes one read of the byte stack memory. A pull that has to take a new
// code walks the prefix chain with one dictionary memory read per step, a
// read state and a walk state each, then finishes and pops the first byte
// (when the code is the one about to be added, its first byte is pushed as
// the code is taken); clear codes before it are taken in the code state.
// The dictionary write overlaps the last walk step. The dictionary and the
// byte stack are synchronous RAMs that need no clearing after reset.
module gif_lzw_decoder #(
  parameter int DICT_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,    // min_code_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] data_byte
  input  logic [1:0]  in_tuser,     // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] out_byte
  output logic [2:0]  out_tuser     // [2:0] status
);

  localparam int AW = $clog2(DICT_ENTRIES);
  localparam int DW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_POP, S_CODE, S_WALK_RD, S_WALK, S_FINISH, S_OUT
  } state_t;

  state_t state_r;
  logic [3:0]  min_size_r;
  logic [19:0] bit_store_r;
  logic [4:0]  bits_held_r;
  logic [3:0]  code_width_r;
  logic [DW-1:0] next_free_r;
  logic [11:0] prev_code_r;
  logic        prev_valid_r;
  logic [7:0]  prev_first_r;
  logic [DW-1:0] depth_r;
  gld_pkg::run_t run_r;
  logic [1:0]  func_r;
  logic [7:0]  data_r;
  logic [11:0] code_r;
  logic [11:0] walk_r;
  logic [DW-1:0] guard_r;
  logic [2:0]  out_status_r;
  logic [7:0]  out_byte_r;
  logic        out_valid_r;

  // Dictionary and stack memories
  logic [11:0] prefix_mem [DICT_ENTRIES];
  logic [7:0]  suffix_mem [DICT_ENTRIES];
  logic [7:0]  stack_mem  [DICT_ENTRIES];
  logic [11:0] prefix_q;
  logic [7:0]  suffix_q;
  logic [7:0]  stack_q;
  logic        dict_we;
  logic [AW-1:0] dict_wa;
  logic [AW-1:0] dict_ra;
  logic        stk_we;
  logic [AW-1:0] stk_wa;
  logic [7:0]  stk_wd;
  logic [AW-1:0] stk_ra;

  // Literal size, clamped
  logic [3:0]  lit_size;
  logic [12:0] clear_code;
  always_comb begin
    lit_size = min_size_r;
    if (lit_size < 4'd1) lit_size = 4'd1;
    if (lit_size > 4'd8) lit_size = 4'd8;
    clear_code = 13'd1 << lit_size;
  end

  // Next code from the bit store
  logic [11:0] code_mask;
  logic [11:0] new_code;
  assign code_mask = 12'((13'd1 << code_width_r) - 13'd1);
  assign new_code  = bit_store_r[11:0] & code_mask;

  // Chain walk condition
  logic walk_more;
  assign walk_more = ({1'b0, walk_r} >= clear_code) && (32'(walk_r) < DICT_ENTRIES)
                     && (32'(guard_r) < DICT_ENTRIES);

  logic stk_room;
  assign stk_room = 32'(depth_r) < DICT_ENTRIES;

  // New entry takes the root byte of the string just walked
  always_ff @(posedge clk) begin
    if (dict_we) begin
      prefix_mem[dict_wa] <= prev_code_r;
      suffix_mem[dict_wa] <= walk_r[7:0];
    end
    prefix_q <= prefix_mem[dict_ra];
    suffix_q <= suffix_mem[dict_ra];
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stack_q <= stack_mem[stk_ra];
  end

  // Memory port control
  logic [DW-1:0] depth_m1;
  assign depth_m1 = depth_r - DW'(1);
  assign dict_ra  = walk_r[AW-1:0];
  assign stk_ra   = depth_m1[AW-1:0];
  always_comb begin
    stk_we  = 1'b0;
    stk_wa  = depth_r[AW-1:0];
    stk_wd  = suffix_q;
    dict_we = 1'b0;
    dict_wa = next_free_r[AW-1:0];
    unique case (state_r)
      S_CODE: begin
        if (run_r == gld_pkg::RUN_OK && depth_r == '0 && bits_held_r >= 5'(code_width_r)
            && {1'b0, new_code} != clear_code && {1'b0, new_code} != clear_code + 13'd1
            && (DW'(new_code) == next_free_r) && prev_valid_r && stk_room) begin
          stk_we = 1'b1;
          stk_wd = prev_first_r;
        end
      end
      S_WALK: begin
        if (walk_more) stk_we = stk_room;
        else begin
          stk_we  = stk_room;
          stk_wd  = walk_r[7:0];
          dict_we = prev_valid_r && (32'(next_free_r) < DICT_ENTRIES);
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      min_size_r   <= 4'd8;
      bit_store_r  <= '0;
      bits_held_r  <= '0;
      code_width_r <= 4'd9;
      next_free_r  <= DW'(258);
      prev_code_r  <= '0;
      prev_valid_r <= 1'b0;
      prev_first_r <= '0;
      depth_r      <= '0;
      run_r        <= gld_pkg::RUN_OK;
      out_valid_r  <= 1'b0;
      out_status_r <= '0;
      out_byte_r   <= '0;
    end else begin
      if (cfg_we) min_size_r <= cfg_wdata;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        // Capture an item
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            func_r  <= in_tuser;
            data_r  <= in_tdata;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          out_byte_r <= '0;
          case (func_r)
            gld_pkg::FUNC_PUSH: begin
              if (bits_held_r <= 5'd12) begin
                bit_store_r  <= bit_store_r | (20'(data_r) << bits_held_r);
                bits_held_r  <= bits_held_r + 5'd8;
                out_status_r <= gld_pkg::ST_OK;
              end else out_status_r <= gld_pkg::ST_FULL;
              state_r <= S_OUT;
            end
            gld_pkg::FUNC_PULL: begin
              if (run_r == gld_pkg::RUN_END) begin
                out_status_r <= gld_pkg::ST_END;
                state_r      <= S_OUT;
              end else if (run_r != gld_pkg::RUN_OK) begin
                out_status_r <= gld_pkg::ST_ERROR;
                state_r      <= S_OUT;
              end else if (depth_r != '0) state_r <= S_POP;
              else state_r <= S_CODE;
            end
            gld_pkg::FUNC_START: begin
              bit_store_r  <= '0;
              bits_held_r  <= '0;
              depth_r      <= '0;
              run_r        <= gld_pkg::RUN_OK;
              code_width_r <= lit_size + 4'd1;
              next_free_r  <= DW'(clear_code + 13'd2);
              prev_code_r  <= '0;
              prev_valid_r <= 1'b0;
              prev_first_r <= '0;
              out_status_r <= gld_pkg::ST_OK;
              state_r      <= S_OUT;
            end
            default: begin
              out_status_r <= gld_pkg::ST_NEED;
              state_r      <= S_OUT;
            end
          endcase
        end
        // Stack read is out; pop it
        S_POP: begin
          depth_r      <= depth_m1;
          out_byte_r   <= stack_q;
          out_status_r <= gld_pkg::ST_BYTE;
          state_r      <= S_OUT;
        end
        // Take the next code
        S_CODE: begin
          if (bits_held_r < 5'(code_width_r)) begin
            out_status_r <= gld_pkg::ST_NEED;
            state_r      <= S_OUT;
          end else begin
            bit_store_r <= bit_store_r >> code_width_r;
            bits_held_r <= bits_held_r - 5'(code_width_r);
            code_r      <= new_code;
            guard_r     <= '0;
            if ({1'b0, new_code} == clear_code) begin
              code_width_r <= lit_size + 4'd1;
              next_free_r  <= DW'(clear_code + 13'd2);
              prev_code_r  <= '0;
              prev_valid_r <= 1'b0;
              prev_first_r <= '0;
            end else if ({1'b0, new_code} == clear_code + 13'd1) begin
              run_r        <= gld_pkg::RUN_END;
              out_status_r <= gld_pkg::ST_END;
              state_r      <= S_OUT;
            end else if (DW'(new_code) < next_free_r && 32'(new_code) < DICT_ENTRIES) begin
              walk_r  <= new_code;
              state_r <= S_WALK_RD;
            end else if (DW'(new_code) == next_free_r && prev_valid_r) begin
              if (stk_room) depth_r <= depth_r + DW'(1);
              walk_r  <= prev_code_r;
              state_r <= S_WALK_RD;
            end else begin
              run_r        <= gld_pkg::RUN_ERROR;
              out_status_r <= gld_pkg::ST_ERROR;
              state_r      <= S_OUT;
            end
          end
        end
        // Wait for the dictionary read of walk_r
        S_WALK_RD: state_r <= S_WALK;
        // Push the suffix and follow the prefix, or finish with the root
        S_WALK: begin
          if (stk_room) depth_r <= depth_r + DW'(1);
          if (walk_more) begin
            walk_r  <= prefix_q;
            guard_r <= guard_r + DW'(1);
            state_r <= S_WALK_RD;
          end else begin
            prev_first_r <= walk_r[7:0];
            if (prev_valid_r && 32'(next_free_r) < DICT_ENTRIES)
              next_free_r <= next_free_r + DW'(1);
            state_r <= S_FINISH;
          end
        end
        // Widen the code and pop the first byte
        S_FINISH: begin
          if (code_width_r < 4'(gld_pkg::MAX_WIDTH)
              && next_free_r == DW'(13'd1 << code_width_r)
              && 32'(next_free_r) < DICT_ENTRIES)
            code_width_r <= code_width_r + 4'd1;
          prev_code_r  <= code_r;
          prev_valid_r <= 1'b1;
          state_r      <= S_POP;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_status_r))
    else $error("result dropped");
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != gld_pkg::ST_BYTE |-> out_byte_r == '0)
    else $error("byte not zero");
  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    code_width_r <= 4'd12)
    else $error("code width too large");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready)
    else $error("accepted while busy");
`endif

endmodule
